/* design/sfdbl_pkg.sv */
// sfdbl_pkg: shared constants, command codes and structs for the framed double buffer loader
// no dependencies; imported by every module of the block
`default_nettype none

package sfdbl_pkg;

   localparam int ROWS        = 16;
   localparam int ROW_BYTES   = 16;
   localparam int PLANE_BYTES = ROWS * ROW_BYTES;
   localparam int FRAME_BYTES = 2 * PLANE_BYTES;
   localparam int MEM_BYTES   = 2 * FRAME_BYTES;
   localparam int ADDR_W      = $clog2(MEM_BYTES);
   localparam int CNT_W       = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

   localparam int CMD_W   = 2;
   localparam int BYTE_W  = 8;
   localparam int ROW_W   = 4;
   localparam int COL_W   = 4;
   localparam int CSR_W   = 1;
   localparam int REQ_W   = 24;
   localparam int RSP_W   = 16;

   localparam logic [CMD_W-1:0] CMD_RX        = 2'd0;
   localparam logic [CMD_W-1:0] CMD_FRAME_END = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ      = 2'd2;

   localparam logic [CSR_W-1:0] CSR_SYNC_FIRST  = 1'b0;
   localparam logic [CSR_W-1:0] CSR_SYNC_SECOND = 1'b1;

   localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd83;
   localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd67;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [BYTE_W-1:0] rx_byte;
      logic              read_color;
      logic [ROW_W-1:0]  read_row;
      logic [COL_W-1:0]  read_column;
   } req_item_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } mem_op_type;

   typedef struct packed {
      logic data_en;
      logic receive_ready;
      logic frame_done;
      logic shown_buffer;
      logic byte_dropped;
   } rsp_status_type;

endpackage

`default_nettype wire

/* design/sfdbl_frame_mem.sv */
// sfdbl_frame_mem: byte-wide frame store for both buffers, one write and one registered read port
// depends on sfdbl_pkg
`default_nettype none

module sfdbl_frame_mem (
   input  wire logic                      clock,
   input  wire sfdbl_pkg::mem_op_type     mem_op,
   output logic [sfdbl_pkg::BYTE_W-1:0]   rd_data
);
   import sfdbl_pkg::*;

   logic [BYTE_W-1:0] mem_array [MEM_BYTES];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_op.wr_en) begin
         mem_array[mem_op.wr_addr] <= mem_op.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_op.rd_en) begin
         rd_data_ff <= mem_array[mem_op.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* design/sfdbl_loader_ctrl.sv */
// sfdbl_loader_ctrl: sync hunt, frame write counter, buffer swap and sync registers
// depends on sfdbl_pkg; drives the frame memory port
`default_nettype none

module sfdbl_loader_ctrl (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_wr_en,
   input  wire logic [sfdbl_pkg::CSR_W-1:0]    csr_index,
   input  wire logic [sfdbl_pkg::BYTE_W-1:0]   csr_wdata,
   input  wire logic                           item_valid,
   input  wire sfdbl_pkg::req_item_type        item,
   output sfdbl_pkg::mem_op_type               mem_op,
   output sfdbl_pkg::rsp_status_type           status
);
   import sfdbl_pkg::*;

   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_DATA   = 2'd2;

   logic [BYTE_W-1:0] sync_first_ff, sync_first_in;
   logic [BYTE_W-1:0] sync_second_ff, sync_second_in;
   logic [1:0]        phase_ff, phase_in;
   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic              select_ff, select_in;
   logic              pending_ff, pending_in;
   logic [1:0]        filled_ff, filled_in;
   logic              back;
   logic              last_byte;
   logic              in_frame;
   logic              done;
   logic              dropped;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;

   always_comb begin
      sync_first_in  = sync_first_ff;
      sync_second_in = sync_second_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  sync_first_in  = csr_wdata;
            CSR_SYNC_SECOND: sync_second_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign back      = ~select_ff;
   assign last_byte = (byte_count_ff == CNT_W'(FRAME_BYTES - 1));
   assign in_frame  = (int'(item.read_row) < ROWS) && (int'(item.read_column) < ROW_BYTES);

   assign wr_addr = back ? ADDR_W'(FRAME_BYTES) + ADDR_W'(byte_count_ff)
                         : ADDR_W'(byte_count_ff);
   assign rd_addr = (select_ff ? ADDR_W'(FRAME_BYTES) : '0)
                  + (item.read_color ? ADDR_W'(PLANE_BYTES) : '0)
                  + ADDR_W'(item.read_row) * ADDR_W'(ROW_BYTES)
                  + ADDR_W'(item.read_column);

   always_comb begin
      phase_in      = phase_ff;
      byte_count_in = byte_count_ff;
      select_in     = select_ff;
      pending_in    = pending_ff;
      filled_in     = filled_ff;
      done          = 1'b0;
      dropped       = 1'b0;
      mem_op        = '0;
      mem_op.wr_addr = wr_addr;
      mem_op.wr_data = item.rx_byte;
      mem_op.rd_addr = rd_addr;
      if (item_valid) begin
         case (item.command)
            CMD_RX: begin
               if (pending_ff) begin
                  dropped = 1'b1;
               end else begin
                  unique case (phase_ff)
                     PH_SECOND: begin
                        phase_in      = (item.rx_byte == sync_second_ff) ? PH_DATA : PH_FIRST;
                        byte_count_in = '0;
                     end
                     PH_DATA: begin
                        mem_op.wr_en = 1'b1;
                        if (last_byte) begin
                           byte_count_in   = '0;
                           phase_in        = PH_FIRST;
                           pending_in      = 1'b1;
                           filled_in[back] = 1'b1;
                           done            = 1'b1;
                        end else begin
                           byte_count_in = byte_count_ff + CNT_W'(1);
                        end
                     end
                     default: begin
                        phase_in = (item.rx_byte == sync_first_ff) ? PH_SECOND : PH_FIRST;
                     end
                  endcase
               end
            end
            CMD_FRAME_END: begin
               if (pending_ff) begin
                  select_in     = ~select_ff;
                  pending_in    = 1'b0;
                  byte_count_in = '0;
               end
            end
            CMD_READ: begin
               mem_op.rd_en = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // a buffer that never received a full frame still reads as zero
   assign status.data_en       = (item.command == CMD_READ) && in_frame && filled_ff[select_ff];
   assign status.receive_ready = ~pending_in;
   assign status.frame_done    = done;
   assign status.shown_buffer  = select_in;
   assign status.byte_dropped  = dropped;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_first_ff  <= SYNC_FIRST_RST;
         sync_second_ff <= SYNC_SECOND_RST;
         phase_ff       <= PH_FIRST;
         byte_count_ff  <= '0;
         select_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         filled_ff      <= '0;
      end else begin
         sync_first_ff  <= sync_first_in;
         sync_second_ff <= sync_second_in;
         phase_ff       <= phase_in;
         byte_count_ff  <= byte_count_in;
         select_ff      <= select_in;
         pending_ff     <= pending_in;
         filled_ff      <= filled_in;
      end
   end

`ifndef SYNTHESIS
   a_done_sets_pending: assert property (@(posedge clock) disable iff (reset)
      item_valid && status.frame_done |=> pending_ff)
      else $error("frame completed without a pending swap");

   a_count_only_in_data: assert property (@(posedge clock) disable iff (reset)
      byte_count_ff != '0 |-> phase_ff == PH_DATA)
      else $error("byte count nonzero outside the data phase");

   a_one_mem_access: assert property (@(posedge clock) disable iff (reset)
      !(mem_op.wr_en && mem_op.rd_en))
      else $error("write and read issued for one word");
`endif

endmodule

`default_nettype wire

/* design/sync_framed_double_buffer_loader_core.sv */
// sync_framed_double_buffer_loader_core: top level of the framed double buffer loader
// depends on sfdbl_pkg, sfdbl_loader_ctrl and sfdbl_frame_mem
`default_nettype none

// Takes one request word per cycle while req_tready is high and returns one response word per request,
// in order. The response leaves the second output entry, fed from the first entry and the registered read
// port of the 1024-byte frame memory; a two-entry output stage keeps requests flowing while a response
// waits, and req_tready drops only when both entries are full. Both buffers read as zero until they first
// receive a complete frame, tracked by one flag per buffer, so no clearing pass follows reset. Sync bytes
// are for the user to write through the csr port only while the block is idle; the block does not enforce it.
module sync_framed_double_buffer_loader_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_wr_en,
   input  wire logic [sfdbl_pkg::CSR_W-1:0]     csr_index,
   input  wire logic [sfdbl_pkg::BYTE_W-1:0]    csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // command[1:0], rx_byte[9:2], read_color[10], read_row[14:11], read_column[18:15]
   input  wire logic [sfdbl_pkg::REQ_W-1:0]     req_tdata,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // read_data[7:0], receive_ready[8], frame_done[9], shown_buffer[10], byte_dropped[11]
   output logic [sfdbl_pkg::RSP_W-1:0]          rsp_tdata
);
   import sfdbl_pkg::*;

   req_item_type   item;
   mem_op_type     mem_op;
   rsp_status_type status;
   logic [BYTE_W-1:0] rd_data;
   logic           accept;
   logic           s1_move;
   logic           s1_valid_ff, s1_valid_in;
   logic           s2_valid_ff, s2_valid_in;
   rsp_status_type s1_stat_ff;
   rsp_status_type s2_stat_ff;
   logic [BYTE_W-1:0] s2_data_ff;

   assign item.command     = req_tdata[1:0];
   assign item.rx_byte     = req_tdata[9:2];
   assign item.read_color  = req_tdata[10];
   assign item.read_row    = req_tdata[14:11];
   assign item.read_column = req_tdata[18:15];

   assign s1_move     = s1_valid_ff && (!s2_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_move;
   assign accept      = req_tvalid && req_tready;
   assign s1_valid_in = accept || (s1_valid_ff && !s1_move);
   assign s2_valid_in = s1_move || (s2_valid_ff && !rsp_tready);

   sfdbl_loader_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (accept),
      .item       (item),
      .mem_op     (mem_op),
      .status     (status)
   );

   sfdbl_frame_mem u_mem (
      .clock   (clock),
      .mem_op  (mem_op),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_stat_ff <= status;
      end
      if (s1_move) begin
         s2_stat_ff <= s1_stat_ff;
         s2_data_ff <= s1_stat_ff.data_en ? rd_data : '0;
      end
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {4'd0, s2_stat_ff.byte_dropped, s2_stat_ff.shown_buffer,
                        s2_stat_ff.frame_done, s2_stat_ff.receive_ready, s2_data_ff};

`ifndef SYNTHESIS
   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> s1_valid_ff && s2_valid_ff)
      else $error("request stalled with a free output entry");

   a_word_kept_on_stall: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !rsp_tready |=> s2_valid_ff)
      else $error("pending response word lost");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted word not held in first stage");
`endif

endmodule

`default_nettype wire

/* dv/sync_framed_double_buffer_loader_core_tb.sv */
// testbench for sync_framed_double_buffer_loader_core: queued request words, in-order response check
// depends on sfdbl_pkg and the core; predicts sync hunt, back buffer load, swap and reads itself
`timescale 1ns / 100ps

module sync_framed_double_buffer_loader_core_tb;
   import sfdbl_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int IDLE_PCT = 6;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES = 150;
   localparam int HOLD_AT = 400;
   localparam int QUIET_FROM = 900;
   localparam int QUIET_TO = 1200;

   typedef enum logic [1:0] {HUNT_FIRST, HUNT_SECOND, LOAD_FRAME} sync_phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] read_data;
      logic              receive_ready;
      logic              frame_done;
      logic              shown_buffer;
      logic              byte_dropped;
   } loader_rsp_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wr_en = 1'b0;
   logic [CSR_W-1:0]    csr_index = '0;
   logic [BYTE_W-1:0]   csr_wdata = '0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tdata = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_W-1:0]    rsp_tdata;

   // pending request words and the responses they should produce
   req_item_type    word_q[$];
   loader_rsp_type  pending_rsp_q[$];
   int unsigned   queued_words = 0;
   int unsigned   req_accepts = 0;
   int unsigned   rsp_accepts = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   quiet_cycles = 0;
   int unsigned   hold_left = 0;
   bit            pressure_done = 1'b0;

   // predicted block state
   logic [BYTE_W-1:0] sync_first_q = SYNC_FIRST_RST;
   logic [BYTE_W-1:0] sync_second_q = SYNC_SECOND_RST;
   sync_phase_type    phase = HUNT_FIRST;
   int unsigned       load_count = 0;
   bit                front_sel = 1'b0;
   bit                swap_armed = 1'b0;
   bit [BYTE_W-1:0]   frame_store [MEM_BYTES];

   sync_framed_double_buffer_loader_core DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic predict_response(input req_item_type it, output loader_rsp_type r);
      int unsigned addr;
      r = '0;
      case (it.command)
         CMD_RX: begin
            if (swap_armed) begin
               r.byte_dropped = 1'b1;
            end else if (phase == HUNT_SECOND) begin
               phase = (it.rx_byte == sync_second_q) ? LOAD_FRAME : HUNT_FIRST;
               load_count = 0;
            end else if (phase == LOAD_FRAME) begin
               addr = (front_sel ? 0 : FRAME_BYTES) + load_count;
               frame_store[ADDR_W'(addr)] = it.rx_byte;
               load_count++;
               if (load_count >= FRAME_BYTES) begin
                  load_count = 0;
                  phase = HUNT_FIRST;
                  swap_armed = 1'b1;
                  r.frame_done = 1'b1;
               end
            end else begin
               phase = (it.rx_byte == sync_first_q) ? HUNT_SECOND : HUNT_FIRST;
            end
         end
         CMD_FRAME_END: begin
            if (swap_armed) begin
               front_sel = ~front_sel;
               swap_armed = 1'b0;
               load_count = 0;
            end
         end
         CMD_READ: begin
            if (it.read_row < ROWS && it.read_column < ROW_BYTES) begin
               addr = front_sel * FRAME_BYTES + it.read_color * PLANE_BYTES
                    + it.read_row * ROW_BYTES + it.read_column;
               r.read_data = frame_store[ADDR_W'(addr)];
            end
         end
         default: ;
      endcase
      r.receive_ready = ~swap_armed;
      r.shown_buffer = front_sel;
   endtask

   // driver
   always @(posedge clock) begin
      loader_rsp_type predicted;
      req_item_type  it;
      bit            idle;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_response(req_item_type'({req_tdata[1:0], req_tdata[9:2], req_tdata[10],
                                              req_tdata[14:11], req_tdata[18:15]}), predicted);
            pending_rsp_q.push_back(predicted);
            req_accepts <= req_accepts + 1;
         end
         if (!req_tvalid || req_tready) begin
            idle = !(req_accepts >= QUIET_FROM && req_accepts < QUIET_TO)
                   && ($urandom_range(0, 99) < IDLE_PCT);
            if (word_q.size() != 0 && !idle) begin
               it = word_q.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, it.read_column, it.read_row, it.read_color,
                             it.rx_byte, it.command};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (!pressure_done && req_accepts >= HOLD_AT) begin
         pressure_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= (req_accepts >= QUIET_FROM && req_accepts < QUIET_TO)
                       || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   task automatic report_mismatch(input string field, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("mismatch on %s at response %0d: expected %0h, got %0h",
               field, rsp_accepts, want, got);
      mismatch_count++;
   endtask

   // monitor
   always @(posedge clock) begin
      loader_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp_q.size() == 0) begin
            report_mismatch("unexpected word", 8'h00, rsp_tdata[7:0]);
         end else begin
            want = pending_rsp_q.pop_front();
            if (rsp_tdata[7:0] !== want.read_data)
               report_mismatch("read_data", want.read_data, rsp_tdata[7:0]);
            if (rsp_tdata[8] !== want.receive_ready)
               report_mismatch("receive_ready", 8'(want.receive_ready), 8'(rsp_tdata[8]));
            if (rsp_tdata[9] !== want.frame_done)
               report_mismatch("frame_done", 8'(want.frame_done), 8'(rsp_tdata[9]));
            if (rsp_tdata[10] !== want.shown_buffer)
               report_mismatch("shown_buffer", 8'(want.shown_buffer), 8'(rsp_tdata[10]));
            if (rsp_tdata[11] !== want.byte_dropped)
               report_mismatch("byte_dropped", 8'(want.byte_dropped), 8'(rsp_tdata[11]));
         end
         rsp_accepts <= rsp_accepts + 1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic queue_word(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] rx,
                             input logic color, input logic [ROW_W-1:0] row,
                             input logic [COL_W-1:0] col);
      req_item_type it;
      it.command = cmd;
      it.rx_byte = rx;
      it.read_color = color;
      it.read_row = row;
      it.read_column = col;
      word_q.push_back(it);
      queued_words++;
   endtask

   task automatic queue_random_word(input logic [CMD_W-1:0] cmd);
      queue_word(cmd, BYTE_W'($urandom), 1'($urandom), ROW_W'($urandom), COL_W'($urandom));
   endtask

   task automatic queue_rx(input logic [BYTE_W-1:0] rx);
      queue_word(CMD_RX, rx, 1'($urandom), ROW_W'($urandom), COL_W'($urandom));
   endtask

   // sync pair, one full frame with reads and early frame ends mixed in, dropped bytes, swap, reads
   task automatic queue_frame();
      queue_rx(sync_first_q);
      queue_rx(sync_second_q);
      for (int i = 0; i < FRAME_BYTES; i++) begin
         if ($urandom_range(0, 19) == 0)
            queue_random_word(CMD_READ);
         if ($urandom_range(0, 149) == 0)
            queue_random_word(CMD_FRAME_END);
         queue_rx(BYTE_W'($urandom));
      end
      repeat ($urandom_range(0, 4)) queue_rx(BYTE_W'($urandom));
      repeat ($urandom_range(0, 3)) queue_random_word(CMD_READ);
      if ($urandom_range(0, 3) == 0)
         queue_random_word(CMD_UNUSED);
      queue_random_word(CMD_FRAME_END);
      repeat ($urandom_range(2, 10)) queue_random_word(CMD_READ);
   endtask

   task automatic queue_broken_sync();
      logic [BYTE_W-1:0] wrong;
      queue_rx(sync_first_q);
      if ($urandom_range(0, 1) == 0) begin
         queue_rx(sync_first_q);
      end else begin
         do wrong = BYTE_W'($urandom); while (wrong == sync_second_q);
         queue_rx(wrong);
      end
      queue_rx(sync_second_q);
      queue_random_word(CMD_READ);
   endtask

   task automatic fill_phase(input int unsigned quota);
      int unsigned start;
      start = queued_words;
      while (queued_words - start < quota) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: queue_frame();
            5, 6, 7: repeat ($urandom_range(4, 16))
               queue_random_word(CMD_W'($urandom_range(0, 3)));
            default: queue_broken_sync();
         endcase
      end
   endtask

   task automatic drain();
      while (word_q.size() != 0 || req_tvalid || pending_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_sync(input logic [CSR_W-1:0] idx, input logic [BYTE_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_SYNC_FIRST)
         sync_first_q = value;
      else
         sync_second_q = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty buffer reads, unused command, idle swap, sync hunt corners
      queue_word(CMD_READ, 8'h00, 1'b0, 4'd0, 4'd0);
      queue_word(CMD_READ, 8'hff, 1'b1, 4'd15, 4'd15);
      queue_word(CMD_READ, 8'h00, 1'b1, 4'd0, 4'd15);
      queue_word(CMD_UNUSED, 8'hff, 1'b1, 4'd15, 4'd15);
      queue_word(CMD_UNUSED, 8'h00, 1'b0, 4'd0, 4'd0);
      queue_word(CMD_FRAME_END, 8'h00, 1'b0, 4'd0, 4'd0);
      queue_rx(8'h00);
      queue_rx(8'hff);
      queue_rx(SYNC_FIRST_RST);
      queue_rx(SYNC_FIRST_RST);
      queue_rx(SYNC_SECOND_RST);
      queue_rx(SYNC_FIRST_RST);
      queue_word(CMD_READ, 8'h00, 1'b0, 4'd7, 4'd8);
      queue_rx(8'hff);
      queue_rx(SYNC_SECOND_RST);
      queue_word(CMD_FRAME_END, 8'hff, 1'b1, 4'd15, 4'd15);

      fill_phase(500);
      drain();

      write_sync(CSR_SYNC_FIRST, 8'h00);
      write_sync(CSR_SYNC_SECOND, 8'hff);
      fill_phase(500);
      drain();

      write_sync(CSR_SYNC_FIRST, 8'hff);
      write_sync(CSR_SYNC_SECOND, 8'h00);
      fill_phase(400);
      drain();
      repeat (8) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
